// ===== rtl/asds_pkg.sv =====
`timescale 1ns / 1ps
package asds_pkg;

    localparam int Q_DEPTH = 32;
    localparam int IDX_W   = $clog2(Q_DEPTH);
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    localparam int LOC_W  = 16;
    localparam int PID_W  = 16;
    localparam int WORD_W = LOC_W + PID_W;
    localparam int TIME_W = 32;
    localparam int SVC_W  = 8;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-3:0] REG_SERVICE_TIME = '0;
    localparam logic [SVC_W-1:0]   SVC_RESET        = SVC_W'(5);

    localparam logic MODE_ENQUEUE = 1'b0;
    localparam logic MODE_SWEEP   = 1'b1;

    // control for the shared compare unit, one slot per cycle
    typedef struct packed {
        logic             en;
        logic             first;
        logic             desc;
        logic [IDX_W-1:0] idx;
    } t_scan_ctl;

endpackage

// ===== rtl/asds_if.sv =====
`timescale 1ns / 1ps
interface asds_req_if import asds_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [LOC_W-1:0] location;
    logic [PID_W-1:0] process_id;

    modport source (output valid, output mode, output location, output process_id,
                    input ready);
    modport sink   (input valid, input mode, input location, input process_id,
                    output ready);
endinterface

interface asds_res_if import asds_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] done_time;
    logic [PID_W-1:0]  served_process;
    logic [LOC_W-1:0]  served_location;
    logic              dropped;
    logic              last;

    modport source (output valid, output done_time, output served_process,
                    output served_location, output dropped, output last,
                    input ready);
    modport sink   (input valid, input done_time, input served_process,
                    input served_location, input dropped, input last,
                    output ready);
endinterface

// ===== rtl/asds_ram.sv =====
`timescale 1ns / 1ps
module asds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data when no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/asds_cfg.sv =====
`timescale 1ns / 1ps
module asds_cfg import asds_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [SVC_W-1:0]   o_service_time
);
    logic [SVC_W-1:0] r_service_time;
    logic             w_hit;

    assign w_hit  = paddr[PADDR_W-1:2] == REG_SERVICE_TIME;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_service_time <= SVC_RESET;
        end else if (psel && penable && pwrite && pready && w_hit) begin
            r_service_time <= pwdata[SVC_W-1:0];
        end
    end

    assign prdata         = w_hit ? PDATA_W'(r_service_time) : '0;
    assign o_service_time = r_service_time;
endmodule

// ===== rtl/asds_scan.sv =====
`timescale 1ns / 1ps
module asds_scan import asds_pkg::*; (
    input  logic              i_clk,
    input  t_scan_ctl         i_ctl,
    input  logic [WORD_W-1:0] i_word,
    output logic [IDX_W-1:0]  o_best_idx,
    output logic [WORD_W-1:0] o_best_word
);
    logic [IDX_W-1:0]  r_best_idx;
    logic [WORD_W-1:0] r_best_word;
    logic [LOC_W-1:0]  w_loc;
    logic [LOC_W-1:0]  w_best_loc;
    logic              w_better;

    assign w_loc      = i_word[WORD_W-1:PID_W];
    assign w_best_loc = r_best_word[WORD_W-1:PID_W];
    // strict compare: on equal locations the lower slot stays
    assign w_better   = i_ctl.desc ? (w_loc > w_best_loc) : (w_loc < w_best_loc);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en && (i_ctl.first || w_better)) begin
            r_best_idx  <= i_ctl.idx;
            r_best_word <= i_word;
        end
    end

    assign o_best_idx  = r_best_idx;
    assign o_best_word = r_best_word;
endmodule

// ===== rtl/alternating_sweep_disk_scheduler.sv =====
`timescale 1ns / 1ps
// Request item: taken while idle; a refused request (table full) goes to the drop state and
//   shows its result once the output is free; the block is ready again once it is loaded.
// Sweep item over n queued requests: each served request takes, for the k slots left,
//   k reads through the single slot-RAM port and the compare unit, a drain state and an
//   emit state that waits for a free output; ready stays low meanwhile.
// Reset (synchronous, active low) clears count, direction, clock and result valid and
//   sets service_time to 5; the slot RAM is not cleared and needs no clearing pass.
module alternating_sweep_disk_scheduler import asds_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    asds_req_if.sink           i_req,
    asds_res_if.source         o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_EMIT,
        S_DROP
    } t_state;

    // sequencer and queue state
    t_state            r_state,     n_state;
    logic [CNT_W-1:0]  r_count,     n_count;
    logic              r_desc,      n_desc;
    logic [TIME_W-1:0] r_clock,     n_clock;
    logic [IDX_W-1:0]  r_rd_idx,    n_rd_idx;
    logic              r_cmp_en,    n_cmp_en;
    logic [IDX_W-1:0]  r_cmp_idx,   n_cmp_idx;
    logic [LOC_W-1:0]  r_in_loc,    n_in_loc;
    logic [PID_W-1:0]  r_in_pid,    n_in_pid;

    // result register
    logic              r_out_valid, n_out_valid;
    logic [TIME_W-1:0] r_out_time,  n_out_time;
    logic [PID_W-1:0]  r_out_pid,   n_out_pid;
    logic [LOC_W-1:0]  r_out_loc,   n_out_loc;
    logic              r_out_drop,  n_out_drop;
    logic              r_out_last,  n_out_last;

    logic [SVC_W-1:0]  w_service_time;
    logic [TIME_W-1:0] w_next_clock;
    logic              w_out_free;
    logic              w_full;
    logic [CNT_W-1:0]  w_last_idx;
    logic              w_enqueue;
    logic              w_emit;

    logic              w_ram_we;
    logic [IDX_W-1:0]  w_ram_waddr;
    logic [WORD_W-1:0] w_ram_wdata;
    logic              w_ram_re;
    logic [WORD_W-1:0] w_ram_rdata;

    t_scan_ctl         w_scan_ctl;
    logic [IDX_W-1:0]  w_best_idx;
    logic [WORD_W-1:0] w_best_word;

    asds_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_service_time (w_service_time)
    );

    // slot table: location in the upper half, process id in the lower half
    asds_ram #(
        .WIDTH (WORD_W),
        .DEPTH (Q_DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_rd_idx),
        .o_rdata (w_ram_rdata)
    );

    // compare unit sees one slot per cycle, in the cycle after its read address is issued
    assign w_scan_ctl.en    = r_cmp_en;
    assign w_scan_ctl.first = r_cmp_idx == '0;
    assign w_scan_ctl.desc  = r_desc;
    assign w_scan_ctl.idx   = r_cmp_idx;

    asds_scan u_scan (
        .i_clk       (i_clk),
        .i_ctl       (w_scan_ctl),
        .i_word      (w_ram_rdata),
        .o_best_idx  (w_best_idx),
        .o_best_word (w_best_word)
    );

    assign i_req.ready  = r_state == S_IDLE;
    assign w_out_free   = !r_out_valid || o_res.ready;
    assign w_full       = r_count == CNT_W'(Q_DEPTH);
    assign w_last_idx   = r_count - CNT_W'(1);
    assign w_next_clock = r_clock + TIME_W'(w_service_time);
    assign w_enqueue    = (r_state == S_IDLE) && i_req.valid && (i_req.mode == MODE_ENQUEUE)
                          && !w_full;
    assign w_emit       = (r_state == S_EMIT) && w_out_free;

    // Enqueue appends at the fill count. On service the last slot, which the scan read
    // last and the RAM still holds on its read port, moves into the freed slot.
    assign w_ram_we    = w_enqueue || w_emit;
    assign w_ram_waddr = w_emit ? w_best_idx : r_count[IDX_W-1:0];
    assign w_ram_wdata = w_emit ? w_ram_rdata : {i_req.location, i_req.process_id};
    assign w_ram_re    = r_state == S_SCAN;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_desc      = r_desc;
        n_clock     = r_clock;
        n_rd_idx    = r_rd_idx;
        n_cmp_en    = r_state == S_SCAN;
        n_cmp_idx   = r_rd_idx;
        n_in_loc    = r_in_loc;
        n_in_pid    = r_in_pid;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_time  = r_out_time;
        n_out_pid   = r_out_pid;
        n_out_loc   = r_out_loc;
        n_out_drop  = r_out_drop;
        n_out_last  = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_in_loc = i_req.location;
                    n_in_pid = i_req.process_id;
                    if (i_req.mode == MODE_ENQUEUE) begin
                        if (w_full) begin
                            n_state = S_DROP;
                        end else begin
                            n_count = r_count + CNT_W'(1);
                        end
                    end else if (r_count == '0) begin
                        // empty sweep: flip direction only
                        n_desc = !r_desc;
                    end else begin
                        n_rd_idx = '0;
                        n_state  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // advance the read address up to the last occupied slot
                if (CNT_W'(r_rd_idx) == w_last_idx) begin
                    n_state = S_WAIT;
                end else begin
                    n_rd_idx = r_rd_idx + IDX_W'(1);
                end
            end
            S_WAIT: begin
                // last slot reaches the compare unit
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_time  = w_next_clock;
                    n_out_pid   = w_best_word[PID_W-1:0];
                    n_out_loc   = w_best_word[WORD_W-1:PID_W];
                    n_out_drop  = 1'b0;
                    n_out_last  = r_count == CNT_W'(1);
                    n_clock     = w_next_clock;
                    n_count     = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_desc  = !r_desc;
                        n_state = S_IDLE;
                    end else begin
                        n_rd_idx = '0;
                        n_state  = S_SCAN;
                    end
                end
            end
            S_DROP: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_time  = '0;
                    n_out_pid   = r_in_pid;
                    n_out_loc   = r_in_loc;
                    n_out_drop  = 1'b1;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_desc      <= 1'b0;
            r_clock     <= '0;
            r_rd_idx    <= '0;
            r_cmp_en    <= 1'b0;
            r_cmp_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_desc      <= n_desc;
            r_clock     <= n_clock;
            r_rd_idx    <= n_rd_idx;
            r_cmp_en    <= n_cmp_en;
            r_cmp_idx   <= n_cmp_idx;
            r_out_valid <= n_out_valid;
        end
        r_in_loc   <= n_in_loc;
        r_in_pid   <= n_in_pid;
        r_out_time <= n_out_time;
        r_out_pid  <= n_out_pid;
        r_out_loc  <= n_out_loc;
        r_out_drop <= n_out_drop;
        r_out_last <= n_out_last;
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.done_time       = r_out_time;
    assign o_res.served_process  = r_out_pid;
    assign o_res.served_location = r_out_loc;
    assign o_res.dropped         = r_out_drop;
    assign o_res.last            = r_out_last;

    // fill count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(Q_DEPTH))
        else $error("slot count above table depth");

    // a refused request only happens with a full table
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DROP) |-> w_full)
        else $error("drop without full table");

    // scan reads only occupied slots
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNT_W'(r_rd_idx) < r_count))
        else $error("scan read beyond occupied slots");

    // serving the final request empties the table, flips direction and goes idle
    a_sweep_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_count == CNT_W'(1)) |=>
            (r_count == '0 && r_state == S_IDLE && r_desc != $past(r_desc)
             && o_res.valid && o_res.last))
        else $error("sweep did not close on final request");
endmodule

// ===== sim/alternating_sweep_disk_scheduler_test.sv =====
`timescale 1ns / 1ps
module alternating_sweep_disk_scheduler_test;
    import asds_pkg::*;

    // Let the block settle this long once the last completion has come back:
    // an empty sweep or an accepted request returns nothing but may still be busy.
    localparam int TAIL_CYCLES = 40;
    // Receiver hold used to back the block up into its own input.
    localparam int LONG_HOLD   = 600;
    // Stop after roughly this many items in total.
    localparam int ITEM_TARGET = 112;
    // Byte address of the service-time register.
    localparam logic [PADDR_W-1:0] SVC_ADDR = {REG_SERVICE_TIME, 2'b00};

    typedef struct packed {
        logic             mode;
        logic [LOC_W-1:0] location;
        logic [PID_W-1:0] process_id;
    } disk_cmd_t;

    typedef struct packed {
        logic [TIME_W-1:0] done_time;
        logic [PID_W-1:0]  process_id;
        logic [LOC_W-1:0]  location;
        logic              dropped;
        logic              last;
    } completion_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_TOGGLE,
        STALL_HEAVY
    } stall_style_t;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    asds_req_if req_if ();
    asds_res_if res_if ();

    alternating_sweep_disk_scheduler uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Scheduler shadow: slot table, count, sweep direction, disk clock and
    // the service time last written to the block.
    // ------------------------------------------------------------------
    logic [LOC_W-1:0]  tbl_loc [Q_DEPTH];
    logic [PID_W-1:0]  tbl_pid [Q_DEPTH];
    int                queued      = 0;
    logic              descending  = 1'b0;
    logic [TIME_W-1:0] disk_clock  = '0;
    logic [SVC_W-1:0]  svc_setting = SVC_RESET;

    disk_cmd_t   cmd_backlog [$];      // items waiting for the driver
    completion_t owed_completions [$]; // results the block still owes us

    int items_queued  = 0;
    int items_taken   = 0;
    int n_requests    = 0;
    int n_sweeps      = 0;
    int n_drops       = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int holds_asked   = 0;
    int holds_granted = 0;

    // Apply one accepted item to the shadow and queue up the completions it owes.
    function automatic void schedule_item(input disk_cmd_t cmd);
        int          best;
        completion_t c;
        if (cmd.mode == MODE_ENQUEUE) begin
            n_requests++;
            if (queued >= Q_DEPTH) begin
                // Table full: refuse the request, clock untouched, time reported as zero.
                c.done_time  = '0;
                c.process_id = cmd.process_id;
                c.location   = cmd.location;
                c.dropped    = 1'b1;
                c.last       = 1'b1;
                owed_completions.push_back(c);
                n_drops++;
            end else begin
                tbl_loc[queued] = cmd.location;
                tbl_pid[queued] = cmd.process_id;
                queued++;
            end
        end else begin
            n_sweeps++;
            while (queued > 0) begin
                // Pick by location only; a tie keeps the lowest slot.
                best = 0;
                for (int i = 1; i < queued; i++) begin
                    if (descending ? (tbl_loc[i] > tbl_loc[best])
                                   : (tbl_loc[i] < tbl_loc[best]))
                        best = i;
                end
                c.process_id = tbl_pid[best];
                c.location   = tbl_loc[best];
                // Fill the hole with the last occupied slot.
                queued--;
                tbl_loc[best] = tbl_loc[queued];
                tbl_pid[best] = tbl_pid[queued];
                disk_clock    = disk_clock + TIME_W'(svc_setting);
                c.done_time   = disk_clock;
                c.dropped     = 1'b0;
                c.last        = (queued == 0);
                owed_completions.push_back(c);
            end
            // Direction flips on every sweep, empty ones included.
            descending = ~descending;
        end
    endfunction

    function automatic void report_mismatch(input string what, input completion_t exp_c,
                                            input completion_t got_c);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: expected time=%0h pid=%0h loc=%0h drop=%0b last=%0b, got time=%0h pid=%0h loc=%0h drop=%0b last=%0b",
                     $realtime, what, exp_c.done_time, exp_c.process_id, exp_c.location,
                     exp_c.dropped, exp_c.last, got_c.done_time, got_c.process_id,
                     got_c.location, got_c.dropped, got_c.last);
    endfunction

    // ------------------------------------------------------------------
    // Clock; known levels on every block input from time zero.
    // ------------------------------------------------------------------
    initial begin
        req_if.valid      = 1'b0;
        req_if.mode       = MODE_ENQUEUE;
        req_if.location   = '0;
        req_if.process_id = '0;
        res_if.ready      = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driver: offer items from the backlog in bursts with random gaps.
    // Hold an offered item until the block takes it.
    // ------------------------------------------------------------------
    int        burst_left = 1;
    int        gap_left   = 0;
    disk_cmd_t next_cmd;

    always @(posedge clk) begin
        if (!rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                schedule_item('{req_if.mode, req_if.location, req_if.process_id});
                items_taken++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    next_cmd = cmd_backlog.pop_front();
                    req_if.valid      <= 1'b1;
                    req_if.mode       <= next_cmd.mode;
                    req_if.location   <= next_cmd.location;
                    req_if.process_id <= next_cmd.process_id;
                    if (burst_left <= 1) begin
                        // New burst; about a third of the time no gap at all.
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver ready: a long hold when asked, else a stall style that
    // is redrawn at random intervals.
    // ------------------------------------------------------------------
    int           hold_left    = 0;
    int           pattern_left = 0;
    stall_style_t stall_style  = STALL_NONE;

    always @(posedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else if (holds_granted != holds_asked) begin
            holds_granted++;
            hold_left = LONG_HOLD - 1;
            res_if.ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                stall_style  = stall_style_t'($urandom_range(0, 3));
                pattern_left = $urandom_range(16, 80);
            end else begin
                pattern_left--;
            end
            case (stall_style)
                STALL_NONE:   res_if.ready <= 1'b1;
                STALL_LIGHT:  res_if.ready <= ($urandom_range(0, 3) != 0);
                STALL_TOGGLE: res_if.ready <= ~res_if.ready;
                default:      res_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check every accepted result against the oldest owed one.
    // ------------------------------------------------------------------
    completion_t got_c;
    completion_t exp_c;

    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            got_c = '{res_if.done_time, res_if.served_process, res_if.served_location,
                      res_if.dropped, res_if.last};
            if (owed_completions.size() == 0) begin
                report_mismatch("unexpected result", '0, got_c);
            end else begin
                exp_c = owed_completions.pop_front();
                if (got_c.done_time !== exp_c.done_time
                        || got_c.process_id !== exp_c.process_id
                        || got_c.location !== exp_c.location
                        || got_c.dropped !== exp_c.dropped
                        || got_c.last !== exp_c.last)
                    report_mismatch("result mismatch", exp_c, got_c);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_item(input logic mode, input logic [LOC_W-1:0] loc,
                             input logic [PID_W-1:0] pid);
        cmd_backlog.push_back('{mode, loc, pid});
        items_queued++;
    endtask

    task automatic push_request(input logic [LOC_W-1:0] loc, input logic [PID_W-1:0] pid);
        push_item(MODE_ENQUEUE, loc, pid);
    endtask

    task automatic push_sweep();
        // Location and pid are don't-care on a sweep; randomize them anyway.
        push_item(MODE_SWEEP, LOC_W'($urandom), PID_W'($urandom));
    endtask

    // Wait until every item is taken and every completion is back, then let it settle.
    task automatic wait_idle();
        while (items_taken != items_queued || owed_completions.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, access cycle, register lands at the access edge.
    task automatic write_service_time(input logic [SVC_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SVC_ADDR;
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        svc_setting = value;
    endtask

    // Random groups of requests, each closed by a sweep. Narrow location sets
    // force ties; the odd extra sweep drains nothing and only flips direction.
    task automatic push_random_groups(input int stop_at);
        int  group_size;
        bit  narrow;
        while (items_queued < stop_at) begin
            group_size = $urandom_range(1, 10);
            narrow     = ($urandom_range(0, 2) == 0);
            repeat (group_size)
                push_request(narrow ? LOC_W'($urandom_range(0, 3)) : LOC_W'($urandom),
                             PID_W'($urandom));
            push_sweep();
            if ($urandom_range(0, 5) == 0)
                push_sweep();
        end
    endtask

    logic [SVC_W-1:0] last_setting;

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset service time. Two empty sweeps first: direction
        // must flip twice and no results come back.
        push_sweep();
        push_sweep();
        // Field extremes and ties on location (lowest slot must win).
        push_request(16'h0000, 16'hFFFF);
        push_request(16'hFFFF, 16'h0000);
        push_request(16'd100,  16'd1);
        push_request(16'd100,  16'd2);
        push_request(16'd100,  16'd3);
        push_request(16'h0000, 16'h1234);
        push_request(16'hFFFF, 16'hFFFF);
        push_sweep();                       // ascending
        push_request(16'd5,    16'hAAAA);
        push_request(16'h8000, 16'h5555);
        push_request(16'd5,    16'h00FF);
        push_sweep();                       // descending
        push_request(16'd42,   16'd7);
        push_sweep();                       // single request: first result is last
        wait_idle();

        // Largest service time.
        write_service_time(8'd255);
        push_random_groups(items_queued + 40);
        wait_idle();

        // Smallest service time; overfill the table while the receiver is held
        // off so the block backs up and has to stall its input.
        write_service_time(8'd1);
        push_sweep();
        holds_asked++;
        repeat (Q_DEPTH + 2)
            push_request(LOC_W'($urandom), PID_W'($urandom));
        push_sweep();                       // full 32-result drain
        wait_idle();

        // Zero service time: the clock must stand still.
        write_service_time(8'd0);
        repeat (3) push_request(LOC_W'($urandom), PID_W'($urandom));
        push_sweep();
        wait_idle();

        // Some mid-range setting for the rest.
        last_setting = SVC_W'($urandom_range(2, 254));
        write_service_time(last_setting);
        push_random_groups(ITEM_TARGET);
        wait_idle();

        $display("Ran %0d items (%0d requests, %0d sweeps), checked %0d results, %0d of them drops.",
                 items_taken, n_requests, n_sweeps, results_seen, n_drops);
        $display("Service time 5, 255, 1, 0 and %0d, with one %0d-cycle receiver hold on a full table.",
                 last_setting, LONG_HOLD);
        if (mismatches == 0 && owed_completions.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far above the slowest legal run.
    initial begin
        #5_000_000;
        $display("Timed out with %0d items taken of %0d and %0d results outstanding.",
                 items_taken, items_queued, owed_completions.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/asds_pkg.sv
rtl/asds_if.sv
rtl/asds_ram.sv
rtl/asds_cfg.sv
rtl/asds_scan.sv
rtl/alternating_sweep_disk_scheduler.sv
sim/alternating_sweep_disk_scheduler_test.sv
